>>> sv/msi_pkg.sv
`default_nettype none

package msi_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned CodeW = 3;
  localparam int unsigned TimeW = 32;
  localparam int unsigned VoltW = 16;
  localparam int unsigned CmdW = 16;
  localparam int unsigned WdogW = 16;
  localparam int unsigned MvCfgW = 15;
  localparam int unsigned DbandW = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 80;

  localparam logic [OpW-1:0] OP_TICK = 3'd0;
  localparam logic [OpW-1:0] OP_ESTOP = 3'd1;
  localparam logic [OpW-1:0] OP_ESTOP_CLR = 3'd2;
  localparam logic [OpW-1:0] OP_ARM = 3'd3;
  localparam logic [OpW-1:0] OP_DISARM = 3'd4;
  localparam logic [OpW-1:0] OP_STOP = 3'd5;
  localparam logic [OpW-1:0] OP_DRIVE = 3'd6;
  localparam logic [OpW-1:0] OP_KEEPALIVE = 3'd7;

  localparam logic [CodeW-1:0] RC_NONE = 3'd0;
  localparam logic [CodeW-1:0] RC_ESTOP_ON = 3'd1;
  localparam logic [CodeW-1:0] RC_ESTOP_OFF = 3'd2;
  localparam logic [CodeW-1:0] RC_ARMED = 3'd3;
  localparam logic [CodeW-1:0] RC_DISARMED = 3'd4;
  localparam logic [CodeW-1:0] RC_LOW_VOLT = 3'd5;
  localparam logic [CodeW-1:0] RC_VOLT_OK = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_WATCHDOG = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CUTOFF = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESUME = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REQ_ARM = 3'd4;

  localparam logic [WdogW-1:0] WATCHDOG_RST = 16'd500;
  localparam logic [MvCfgW-1:0] CUTOFF_RST = 15'd10500;
  localparam logic [MvCfgW-1:0] RESUME_RST = 15'd11000;
  localparam logic [DbandW-1:0] DEADBAND_RST = 14'd1638;
  localparam logic REQ_ARM_RST = 1'b1;

  localparam logic [TimeW-1:0] REPORT_SPACING_MS = 32'd2000;
  localparam logic [VoltW-1:0] MIN_VALID_MV = 16'd1000;

  typedef struct packed {
    logic stop;
    logic disable_m;
    logic coast;
    logic run;
    logic target_valid;
    logic signed [CmdW-1:0] left_target;
    logic signed [CmdW-1:0] right_target;
    logic [CodeW-1:0] reply_code;
    logic watchdog_report;
    logic [TimeW-1:0] trip_total;
    logic [2:0] status;
  } result_t;

endpackage

`default_nettype wire

>>> sv/motor_safety_interlock_unit.sv
`default_nettype none

// Safety supervisor for a two-motor drive. Each request on the slave stream is
// a command or a tick (tuser holds the operation) and produces exactly one
// result on the master stream. A request is accepted every cycle while the
// result register is empty or being drained; its result appears in the next
// cycle, set by the single output register after the flag and timer logic.
// Configuration writes take effect at once and are always accepted.
module motor_safety_interlock_unit
  import msi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // now_ms[31:0], voltage_mv[47:32], left_cmd[63:48], right_cmd[79:64]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // operation[2:0]
  input  wire logic [OpW-1:0]      s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // stop_motors[0], disable_motors[1], coast_motors[2], run_motors[3],
  // left_target[19:4], right_target[35:20], reply_code[38:36],
  // watchdog_report[39], trip_total[71:40], status[74:72], zero[79:75]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // target_valid[0]
  output logic                     m_axis_tuser_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [WdogW-1:0] watchdog_q;
  logic [MvCfgW-1:0] cutoff_q, resume_q;
  logic [DbandW-1:0] deadband_q;
  logic req_arm_q;

  logic armed_q, armed_d;
  logic estop_q, estop_d;
  logic latch_q, latch_d;
  logic [TimeW-1:0] last_cmd_q, last_cmd_d;
  logic [TimeW-1:0] last_rep_q, last_rep_d;
  logic [TimeW-1:0] trips_q, trips_d;

  logic out_valid_q;
  result_t res_q, res_d;

  logic in_accept;
  logic [OpW-1:0] op;
  logic [TimeW-1:0] now_ms;
  logic [VoltW-1:0] volt_mv;
  logic signed [CmdW-1:0] left_cmd, right_cmd;
  logic signed [CmdW-1:0] left_db, right_db;
  logic [CmdW:0] left_mag, right_mag;
  logic may_run;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign op = s_axis_tuser_i;
  assign now_ms = s_axis_tdata_i[31:0];
  assign volt_mv = s_axis_tdata_i[47:32];
  assign left_cmd = s_axis_tdata_i[63:48];
  assign right_cmd = s_axis_tdata_i[79:64];

  assign left_mag = left_cmd[CmdW-1] ? (17'd0 - {left_cmd[CmdW-1], left_cmd})
                                     : {1'b0, left_cmd};
  assign right_mag = right_cmd[CmdW-1] ? (17'd0 - {right_cmd[CmdW-1], right_cmd})
                                       : {1'b0, right_cmd};
  assign left_db = (left_mag < {3'd0, deadband_q}) ? '0 : left_cmd;
  assign right_db = (right_mag < {3'd0, deadband_q}) ? '0 : right_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watchdog_q <= WATCHDOG_RST;
      cutoff_q <= CUTOFF_RST;
      resume_q <= RESUME_RST;
      deadband_q <= DEADBAND_RST;
      req_arm_q <= REQ_ARM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WATCHDOG: watchdog_q <= cfg_data_i;
        REG_CUTOFF:   cutoff_q <= cfg_data_i[MvCfgW-1:0];
        REG_RESUME:   resume_q <= cfg_data_i[MvCfgW-1:0];
        REG_DEADBAND: deadband_q <= cfg_data_i[DbandW-1:0];
        REG_REQ_ARM:  req_arm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    armed_d = armed_q;
    estop_d = estop_q;
    latch_d = latch_q;
    last_cmd_d = last_cmd_q;
    last_rep_d = last_rep_q;
    trips_d = trips_q;
    res_d = '0;
    may_run = 1'b0;

    case (op)
      OP_TICK: begin
        if (cutoff_q != '0 && volt_mv > MIN_VALID_MV) begin
          if (!latch_q && volt_mv < {1'b0, cutoff_q}) begin
            latch_d = 1'b1;
            res_d.stop = 1'b1;
            res_d.disable_m = 1'b1;
            res_d.reply_code = RC_LOW_VOLT;
          end else if (latch_q && volt_mv > {1'b0, resume_q}) begin
            latch_d = 1'b0;
            res_d.reply_code = RC_VOLT_OK;
          end
        end
        if ((now_ms - last_cmd_q) > {16'd0, watchdog_q}) begin
          res_d.coast = 1'b1;
          if (armed_q) begin
            trips_d = trips_q + 32'd1;
            if ((now_ms - last_rep_q) > REPORT_SPACING_MS) begin
              res_d.watchdog_report = 1'b1;
              last_rep_d = now_ms;
            end
          end
        end
        may_run = !estop_q && !latch_d && (!req_arm_q || armed_q);
        res_d.run = may_run;
      end
      OP_ESTOP: begin
        estop_d = 1'b1;
        res_d.stop = 1'b1;
        res_d.disable_m = 1'b1;
        res_d.reply_code = RC_ESTOP_ON;
      end
      OP_ESTOP_CLR: begin
        estop_d = 1'b0;
        res_d.reply_code = RC_ESTOP_OFF;
      end
      OP_ARM: begin
        armed_d = 1'b1;
        last_cmd_d = now_ms;
        res_d.reply_code = RC_ARMED;
      end
      OP_DISARM: begin
        armed_d = 1'b0;
        res_d.stop = 1'b1;
        res_d.disable_m = 1'b1;
        res_d.reply_code = RC_DISARMED;
      end
      OP_STOP: begin
        res_d.stop = 1'b1;
        last_cmd_d = now_ms;
      end
      OP_DRIVE: begin
        may_run = !estop_q && !latch_q && (!req_arm_q || armed_q);
        if (!may_run) begin
          res_d.stop = 1'b1;
        end else begin
          res_d.target_valid = 1'b1;
          res_d.left_target = left_db;
          res_d.right_target = right_db;
        end
        last_cmd_d = now_ms;
      end
      OP_KEEPALIVE: begin
        last_cmd_d = now_ms;
      end
      default: ;
    endcase

    res_d.trip_total = trips_d;
    res_d.status = {latch_d, estop_d, armed_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      estop_q <= 1'b0;
      latch_q <= 1'b0;
      last_cmd_q <= '0;
      last_rep_q <= '0;
      trips_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        armed_q <= armed_d;
        estop_q <= estop_d;
        latch_q <= latch_d;
        last_cmd_q <= last_cmd_d;
        last_rep_q <= last_rep_d;
        trips_q <= trips_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = res_q.target_valid;
  assign m_axis_tdata_o = {5'd0, res_q.status, res_q.trip_total, res_q.watchdog_report,
                           res_q.reply_code, res_q.right_target, res_q.left_target,
                           res_q.run, res_q.coast, res_q.disable_m, res_q.stop};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.run && res_q.stop))
    else $error("run and stop requested together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.target_valid |-> !res_q.stop && !res_q.coast)
    else $error("targets given with a stop or coast request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.watchdog_report |-> res_q.coast && res_q.status[0])
    else $error("watchdog report without an armed coast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trips_q != $past(trips_q) |-> $past(in_accept && op == OP_TICK))
    else $error("trip count moved without a tick");

endmodule

`default_nettype wire

>>> verif/interlock_check_pkg.sv
package interlock_check_pkg;

  import msi_pkg::*;

  class interlock_scoreboard;

    logic [WdogW-1:0]  wdog_limit_ms;
    logic [MvCfgW-1:0] cutoff_mv;
    logic [MvCfgW-1:0] resume_mv;
    logic [DbandW-1:0] deadband;
    logic              req_arm;

    logic             armed;
    logic             estopped;
    logic             lv_latch;
    logic [TimeW-1:0] last_cmd_ms;
    logic [TimeW-1:0] last_report_ms;
    logic [TimeW-1:0] trips;

    result_t expected_results[$];

    int unsigned mismatches;
    int unsigned requests_seen;
    int unsigned results_seen;
    int unsigned targets_seen;
    int unsigned reports_seen;

    function new();
      wdog_limit_ms = WATCHDOG_RST;
      cutoff_mv = CUTOFF_RST;
      resume_mv = RESUME_RST;
      deadband = DEADBAND_RST;
      req_arm = REQ_ARM_RST;
      armed = !REQ_ARM_RST;
      estopped = 1'b0;
      lv_latch = 1'b0;
      last_cmd_ms = '0;
      last_report_ms = '0;
      trips = '0;
      mismatches = 0;
      requests_seen = 0;
      results_seen = 0;
      targets_seen = 0;
      reports_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_WATCHDOG: wdog_limit_ms = data[WdogW-1:0];
        REG_CUTOFF:   cutoff_mv = data[MvCfgW-1:0];
        REG_RESUME:   resume_mv = data[MvCfgW-1:0];
        REG_DEADBAND: deadband = data[DbandW-1:0];
        REG_REQ_ARM:  req_arm = data[0];
        default: ;
      endcase
    endfunction

    function bit motors_allowed();
      return !estopped && !lv_latch && !(req_arm && !armed);
    endfunction

    // The magnitude of the most negative command is taken in 32 bits.
    function logic signed [CmdW-1:0] apply_deadband(logic signed [CmdW-1:0] cmd);
      int value;
      int magnitude;
      value = cmd;
      magnitude = (value < 0) ? -value : value;
      return (magnitude < int'(deadband)) ? '0 : cmd;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [TimeW-1:0] now,
                               logic [VoltW-1:0] mv, logic signed [CmdW-1:0] left,
                               logic signed [CmdW-1:0] right);
      result_t r;
      logic [TimeW-1:0] since_cmd;
      logic [TimeW-1:0] since_report;
      r = '0;
      requests_seen++;
      case (op)
        OP_TICK: begin
          if (cutoff_mv != '0 && mv > MIN_VALID_MV) begin
            if (!lv_latch && mv < cutoff_mv) begin
              lv_latch = 1'b1;
              r.stop = 1'b1;
              r.disable_m = 1'b1;
              r.reply_code = RC_LOW_VOLT;
            end else if (lv_latch && mv > resume_mv) begin
              lv_latch = 1'b0;
              r.reply_code = RC_VOLT_OK;
            end
          end
          since_cmd = now - last_cmd_ms;
          if (since_cmd > TimeW'(wdog_limit_ms)) begin
            r.coast = 1'b1;
            if (armed) begin
              trips++;
              since_report = now - last_report_ms;
              if (since_report > REPORT_SPACING_MS) begin
                r.watchdog_report = 1'b1;
                last_report_ms = now;
              end
            end
          end
          r.run = motors_allowed();
        end
        OP_ESTOP: begin
          estopped = 1'b1;
          r.stop = 1'b1;
          r.disable_m = 1'b1;
          r.reply_code = RC_ESTOP_ON;
        end
        OP_ESTOP_CLR: begin
          estopped = 1'b0;
          r.reply_code = RC_ESTOP_OFF;
        end
        OP_ARM: begin
          armed = 1'b1;
          last_cmd_ms = now;
          r.reply_code = RC_ARMED;
        end
        OP_DISARM: begin
          armed = 1'b0;
          r.stop = 1'b1;
          r.disable_m = 1'b1;
          r.reply_code = RC_DISARMED;
        end
        OP_STOP: begin
          r.stop = 1'b1;
          last_cmd_ms = now;
        end
        OP_DRIVE: begin
          if (!motors_allowed()) begin
            r.stop = 1'b1;
          end else begin
            r.left_target = apply_deadband(left);
            r.right_target = apply_deadband(right);
            r.target_valid = 1'b1;
          end
          last_cmd_ms = now;
        end
        default: begin
          last_cmd_ms = now;
        end
      endcase
      r.trip_total = trips;
      r.status = {lv_latch, estopped, armed};
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("stop_motors", want.stop, got.stop);
      check_field("disable_motors", want.disable_m, got.disable_m);
      check_field("coast_motors", want.coast, got.coast);
      check_field("run_motors", want.run, got.run);
      check_field("target_valid", want.target_valid, got.target_valid);
      check_field("left_target", want.left_target, got.left_target);
      check_field("right_target", want.right_target, got.right_target);
      check_field("reply_code", want.reply_code, got.reply_code);
      check_field("watchdog_report", want.watchdog_report, got.watchdog_report);
      check_field("trip_total", want.trip_total, got.trip_total);
      check_field("status", want.status, got.status);
      if (want.target_valid) targets_seen++;
      if (want.watchdog_report) reports_seen++;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

  endclass

endpackage

>>> verif/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import msi_pkg::*;
  import interlock_check_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic [OpW-1:0]      s_user = OP_TICK;
  wire                 s_ready;
  wire                 m_valid;
  logic                m_ready = 1'b0;
  wire [OutDataW-1:0]  m_data;
  wire                 m_user;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_WATCHDOG;
  logic [CfgDataW-1:0] cfg_data = '0;
  wire                 cfg_ready;

  interlock_scoreboard sb = new();

  logic [TimeW-1:0] clock_ms = '0;
  int unsigned cur_cutoff = CUTOFF_RST;
  int unsigned cur_resume = RESUME_RST;
  int unsigned cur_deadband = DEADBAND_RST;
  bit idle_on = 1'b1;

  motor_safety_interlock_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1ms;
    $display("Timed out with %0d results still expected.", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned idle_length();
    int unsigned pick;
    if (!idle_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [CmdW-1:0] random_command();
    logic [CmdW-1:0] v;
    if ($urandom_range(0, 2) == 0) begin
      v = CmdW'($urandom_range(0, cur_deadband + 2));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = CmdW'($urandom);
    end
    return v;
  endfunction

  function automatic result_t unpack_result(logic [OutDataW-1:0] d, logic tv);
    result_t r;
    r.stop = d[0];
    r.disable_m = d[1];
    r.coast = d[2];
    r.run = d[3];
    r.target_valid = tv;
    r.left_target = d[19:4];
    r.right_target = d[35:20];
    r.reply_code = d[38:36];
    r.watchdog_report = d[39];
    r.trip_total = d[71:40];
    r.status = d[74:72];
    return r;
  endfunction

  task automatic send_request(logic [OpW-1:0] op, logic [TimeW-1:0] now,
                             logic [VoltW-1:0] mv, logic [CmdW-1:0] left,
                             logic [CmdW-1:0] right);
    int unsigned gap;
    gap = idle_length();
    repeat (gap) begin
      @(negedge clk_i);
      s_valid = 1'b0;
    end
    @(negedge clk_i);
    s_valid = 1'b1;
    s_user = op;
    s_data = {right, left, mv, now};
    do @(posedge clk_i); while (s_ready !== 1'b1);
    sb.note_request(op, now, mv, left, right);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_settings(int unsigned wd, int unsigned cutoff, int unsigned resume,
                                int unsigned dband, bit need_arm);
    wait_drained();
    write_reg(REG_WATCHDOG, CfgDataW'(wd));
    write_reg(REG_CUTOFF, CfgDataW'(cutoff));
    write_reg(REG_RESUME, CfgDataW'(resume));
    write_reg(REG_DEADBAND, CfgDataW'(dband));
    write_reg(REG_REQ_ARM, CfgDataW'(need_arm));
    cur_cutoff = cutoff;
    cur_resume = resume;
    cur_deadband = dband;
  endtask

  task automatic random_request();
    logic [OpW-1:0] op;
    logic [VoltW-1:0] mv;
    int unsigned pick;
    int lo;
    int hi;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_TICK;
    else if (pick < 60) op = OP_DRIVE;
    else if (pick < 66) op = OP_KEEPALIVE;
    else if (pick < 71) op = OP_STOP;
    else if (pick < 79) op = OP_ARM;
    else if (pick < 84) op = OP_DISARM;
    else if (pick < 89) op = OP_ESTOP;
    else op = OP_ESTOP_CLR;

    pick = $urandom_range(0, 99);
    if (pick < 70) clock_ms += $urandom_range(0, 200);
    else if (pick < 92) clock_ms += $urandom_range(0, 3000);
    else if (pick < 98) clock_ms += $urandom_range(0, 70000);
    else clock_ms = $urandom;

    lo = ((cur_cutoff < cur_resume) ? cur_cutoff : cur_resume) - 300;
    hi = ((cur_cutoff > cur_resume) ? cur_cutoff : cur_resume) + 300;
    if (lo < 0) lo = 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) mv = VoltW'($urandom_range(lo, hi));
    else if (pick < 75) mv = VoltW'($urandom_range(0, 1200));
    else if (pick < 90) mv = VoltW'($urandom_range(0, 30000));
    else mv = VoltW'($urandom);

    send_request(op, clock_ms, mv, random_command(), random_command());
  endtask

  task automatic run_phase(int unsigned count);
    repeat (count) random_request();
  endtask

  initial begin : result_side
    int unsigned stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      // Hold the result side off once so the block fills up and stalls its input.
      if (!held && sb.results_seen >= 300) begin
        held = 1'b1;
        m_ready = 1'b0;
        repeat (250) @(negedge clk_i);
      end
      if (stall > 0) begin
        m_ready = 1'b0;
        stall--;
      end else begin
        m_ready = 1'b1;
        stall = idle_length();
      end
      @(posedge clk_i);
      if (m_valid === 1'b1 && m_ready) sb.check_result(unpack_result(m_data, m_user));
    end
  end

  initial begin : request_side
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(OP_DRIVE, 32'd10, 16'd0, 16'h7fff, 16'h8000);
    send_request(OP_TICK, 32'd100, 16'd12000, 16'h0000, 16'h0000);
    send_request(OP_TICK, 32'd600, 16'd1000, 16'h0000, 16'h0000);
    send_request(OP_ARM, 32'd700, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_DRIVE, 32'd710, 16'd0, 16'h8000, 16'h7fff);
    send_request(OP_DRIVE, 32'd720, 16'd0, 16'd1637, -16'sd1637);
    send_request(OP_DRIVE, 32'd730, 16'd0, 16'd1638, -16'sd1638);
    send_request(OP_TICK, 32'd1230, 16'd10500, 16'h0000, 16'h0000);
    send_request(OP_TICK, 32'd1231, 16'd10499, 16'h0000, 16'h0000);
    send_request(OP_TICK, 32'd2500, 16'd11000, 16'h0000, 16'h0000);
    send_request(OP_TICK, 32'd2600, 16'd11001, 16'h0000, 16'h0000);
    send_request(OP_KEEPALIVE, 32'd2700, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_ESTOP, 32'd2710, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_DRIVE, 32'd2720, 16'd0, 16'h4000, 16'h4000);
    send_request(OP_TICK, 32'd2730, 16'hffff, 16'h0000, 16'h0000);
    send_request(OP_ESTOP_CLR, 32'd2740, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_STOP, 32'd2750, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_DISARM, 32'd2760, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_KEEPALIVE, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(OP_TICK, 32'h0000_0010, 16'd500, 16'h0000, 16'h0000);
    send_request(OP_ARM, 32'h0000_0020, 16'd0, 16'h0000, 16'h0000);
    send_request(OP_TICK, 32'h0000_0400, 16'd12000, 16'h0000, 16'h0000);
    send_request(OP_DRIVE, 32'h0000_0410, 16'd0, 16'h0001, 16'hfffe);
    clock_ms = 32'h0000_0410;

    apply_settings(500, 10500, 11000, 1638, 1'b1);
    run_phase(190);
    apply_settings(0, 0, 0, 0, 1'b0);
    run_phase(190);
    idle_on = 1'b0;
    apply_settings(65535, 30000, 30000, 9830, 1'b1);
    run_phase(190);
    idle_on = 1'b1;
    begin : random_setting
      int unsigned cutoff;
      cutoff = $urandom_range(1001, 28000);
      apply_settings($urandom_range(50, 3000), cutoff, cutoff + $urandom_range(0, 2000),
                     $urandom_range(0, 9830), 1'b1);
    end
    run_phase(190);
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 30000),
                   $urandom_range(0, 30000), $urandom_range(0, 9830), $urandom_range(0, 1));
    write_reg(REG_REQ_ARM + CfgIdxW'($urandom_range(1, 3)), CfgDataW'($urandom));
    run_phase(190);

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests over six register settings, including wrapped time,",
             sb.requests_seen);
    $display("and checked %0d results with %0d drive targets and %0d watchdog reports.",
             sb.results_seen, sb.targets_seen, sb.reports_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/msi_pkg.sv
sv/motor_safety_interlock_unit.sv
verif/interlock_check_pkg.sv
verif/tb_top.sv
